### hdl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants of the JSON string unescaper: result kinds,
// byte classes and the classified item passed from front end to back end.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // result kinds
    localparam logic [2:0] KIND_CHAR       = 3'd0;
    localparam logic [2:0] KIND_DONE       = 3'd1;
    localparam logic [2:0] KIND_BAD_ESCAPE = 3'd2;
    localparam logic [2:0] KIND_BAD_HEX    = 3'd3;
    localparam logic [2:0] KIND_NO_CONT    = 3'd4;
    localparam logic [2:0] KIND_TOO_LONG   = 3'd5;
    localparam logic [2:0] KIND_BAD_FIRST  = 3'd6;

    localparam logic [7:0]  CHAR_QUOTE       = 8'h22;
    localparam logic [7:0]  CHAR_BSLASH      = 8'h5C;
    localparam logic [7:0]  CHAR_U           = 8'h75;
    localparam logic [15:0] REPLACEMENT_UNIT = 16'hFFFD;

    // class of a byte as seen in normal mode
    typedef enum logic [2:0] {
        CLS_ASCII  = 3'd0,
        CLS_QUOTE  = 3'd1,
        CLS_BSLASH = 3'd2,
        CLS_LEAD2  = 3'd3,
        CLS_LEAD3  = 3'd4,
        CLS_LEAD4  = 3'd5,
        CLS_LEAD5  = 3'd6,
        CLS_BAD    = 3'd7
    } jsu_cls_t;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        jsu_cls_t   cls;
        logic       is_cont;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       esc_ok;
        logic [7:0] esc_unit;
    } jsu_item_t;

endpackage

### hdl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Input side: takes raw bytes and classifies them (lead type, hex digit,
// escape character) before they are queued for the decoder.
// ----------------------------------------------------------------------------
module jsu_front (
    input  logic              byte_valid,
    output logic              byte_stall,
    input  logic [7:0]        in_byte,
    input  logic              first_byte,
    input  logic              q_full,
    output logic              push,
    output jsu_pkg::jsu_item_t item
);
    import jsu_pkg::*;

    assign byte_stall = q_full;
    assign push       = byte_valid && !q_full;

    always_comb
    begin
        item          = '0;
        item.data     = in_byte;
        item.first    = first_byte;
        item.is_cont  = (in_byte[7:6] == 2'b10);

        if (in_byte == CHAR_QUOTE)
            item.cls = CLS_QUOTE;
        else if (in_byte == CHAR_BSLASH)
            item.cls = CLS_BSLASH;
        else if (!in_byte[7])
            item.cls = CLS_ASCII;
        else if (in_byte[7:5] == 3'b110)
            item.cls = CLS_LEAD2;
        else if (in_byte[7:4] == 4'b1110)
            item.cls = CLS_LEAD3;
        else if (in_byte[7:3] == 5'b11110)
            item.cls = CLS_LEAD4;
        else if (in_byte[7:2] == 6'b111110)
            item.cls = CLS_LEAD5;
        else
            item.cls = CLS_BAD;

        if (in_byte >= 8'h30 && in_byte <= 8'h39)
        begin
            item.is_hex  = 1'b1;
            item.hex_val = in_byte[3:0];
        end
        else if ((in_byte >= 8'h41 && in_byte <= 8'h46)
                 || (in_byte >= 8'h61 && in_byte <= 8'h66))
        begin
            item.is_hex  = 1'b1;
            item.hex_val = in_byte[3:0] + 4'd9;
        end

        item.esc_ok = 1'b1;
        case (in_byte)
            8'h22:   item.esc_unit = 8'h22;
            8'h2F:   item.esc_unit = 8'h2F;
            8'h5C:   item.esc_unit = 8'h5C;
            8'h62:   item.esc_unit = 8'h08;
            8'h66:   item.esc_unit = 8'h0C;
            8'h6E:   item.esc_unit = 8'h0A;
            8'h72:   item.esc_unit = 8'h0D;
            8'h74:   item.esc_unit = 8'h09;
            default:
            begin
                item.esc_ok   = 1'b0;
                item.esc_unit = 8'h00;
            end
        endcase
    end

endmodule

### hdl/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Short queue of classified bytes between the front end and the decoder.
// ----------------------------------------------------------------------------
module jsu_queue #(
    parameter int DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  jsu_pkg::jsu_item_t wr_item,
    output logic               full,
    input  logic               pop,
    output logic               rd_valid,
    output jsu_pkg::jsu_item_t rd_item
);
    import jsu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    jsu_item_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wr_item;
    end

endmodule

### hdl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Decoder: walks the escape / hex / UTF-8 state for each classified byte
// and holds at most one result in its output register.
// ----------------------------------------------------------------------------
module jsu_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  jsu_pkg::jsu_item_t q_item,
    output logic               pop,
    output logic               unit_valid,
    input  logic               unit_stall,
    output logic [15:0]        code_unit,
    output logic [2:0]         kind
);
    import jsu_pkg::*;

    typedef enum logic [4:0] {
        MODE_NORMAL = 5'b00001,
        MODE_ESC    = 5'b00010,
        MODE_HEX    = 5'b00100,
        MODE_CONT   = 5'b01000,
        MODE_SKIP   = 5'b10000
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [15:0] partial_reg, partial_next;
    logic [1:0]  remain_reg, remain_next;
    logic        open_reg, open_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] unit_reg, unit_next;
    logic [2:0]  kind_reg, kind_next;

    assign pop        = q_valid && (!out_valid_reg || !unit_stall);
    assign unit_valid = out_valid_reg;
    assign code_unit  = unit_reg;
    assign kind       = kind_reg;

    always_comb
    begin : decode
        mode_t       m;
        logic [15:0] p;
        logic [1:0]  r;
        logic        o;
        logic        hit;
        logic        err;
        logic [2:0]  err_kind;
        logic [15:0] res;

        m        = mode_reg;
        p        = partial_reg;
        r        = remain_reg;
        o        = open_reg;
        hit      = 1'b0;
        err      = 1'b0;
        err_kind = KIND_CHAR;
        res      = '0;

        // a first byte drops any sequence in progress
        if (q_item.first)
        begin
            m = MODE_NORMAL;
            p = '0;
            r = '0;
            o = 1'b1;
        end

        if (o)
        begin
            case (m)
                MODE_ESC:
                begin
                    if (q_item.data == CHAR_U)
                    begin
                        p = '0;
                        r = 2'd3;
                        m = MODE_HEX;
                    end
                    else if (q_item.esc_ok)
                    begin
                        m   = MODE_NORMAL;
                        hit = 1'b1;
                        res = {8'h00, q_item.esc_unit};
                    end
                    else
                    begin
                        err      = 1'b1;
                        err_kind = KIND_BAD_ESCAPE;
                    end
                end
                MODE_HEX:
                begin
                    if (!q_item.is_hex)
                    begin
                        err      = 1'b1;
                        err_kind = KIND_BAD_HEX;
                    end
                    else
                    begin
                        p = {p[11:0], q_item.hex_val};
                        if (r == 2'd0)
                        begin
                            m   = MODE_NORMAL;
                            hit = 1'b1;
                            res = p;
                        end
                        else
                            r = r - 2'd1;
                    end
                end
                MODE_CONT:
                begin
                    if (!q_item.is_cont)
                    begin
                        err      = 1'b1;
                        err_kind = KIND_NO_CONT;
                    end
                    else
                    begin
                        p = {p[9:0], q_item.data[5:0]};
                        if (r < 2'd2)
                        begin
                            r   = '0;
                            m   = MODE_NORMAL;
                            hit = 1'b1;
                            res = p;
                        end
                        else
                            r = r - 2'd1;
                    end
                end
                MODE_SKIP:
                begin
                    // tail of a four-byte sequence, taken without checks
                    if (r < 2'd2)
                    begin
                        r = '0;
                        m = MODE_NORMAL;
                    end
                    else
                        r = r - 2'd1;
                end
                default:
                begin
                    m = MODE_NORMAL;
                    case (q_item.cls)
                        CLS_QUOTE:
                        begin
                            err      = 1'b1;
                            err_kind = KIND_DONE;
                        end
                        CLS_BSLASH:
                            m = MODE_ESC;
                        CLS_ASCII:
                        begin
                            hit = 1'b1;
                            res = {8'h00, q_item.data};
                        end
                        CLS_LEAD2:
                        begin
                            p = {11'd0, q_item.data[4:0]};
                            r = 2'd1;
                            m = MODE_CONT;
                        end
                        CLS_LEAD3:
                        begin
                            p = {12'd0, q_item.data[3:0]};
                            r = 2'd2;
                            m = MODE_CONT;
                        end
                        CLS_LEAD4:
                        begin
                            r   = 2'd3;
                            m   = MODE_SKIP;
                            hit = 1'b1;
                            res = REPLACEMENT_UNIT;
                        end
                        CLS_LEAD5:
                        begin
                            err      = 1'b1;
                            err_kind = KIND_TOO_LONG;
                        end
                        default:
                        begin
                            err      = 1'b1;
                            err_kind = KIND_BAD_FIRST;
                        end
                    endcase
                end
            endcase
        end

        // done and every error close the string
        if (err)
        begin
            hit = 1'b1;
            res = '0;
            o   = 1'b0;
            m   = MODE_NORMAL;
            p   = '0;
            r   = '0;
        end

        mode_next      = mode_reg;
        partial_next   = partial_reg;
        remain_next    = remain_reg;
        open_next      = open_reg;
        out_valid_next = out_valid_reg && unit_stall;
        unit_next      = unit_reg;
        kind_next      = kind_reg;

        if (pop)
        begin
            mode_next    = m;
            partial_next = p;
            remain_next  = r;
            open_next    = o;
            if (hit)
            begin
                out_valid_next = 1'b1;
                unit_next      = res;
                kind_next      = err ? err_kind : KIND_CHAR;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_NORMAL;
            partial_reg   <= '0;
            remain_reg    <= '0;
            open_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            partial_reg   <= partial_next;
            remain_reg    <= remain_next;
            open_reg      <= open_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unit_reg <= unit_next;
        kind_reg <= kind_next;
    end

endmodule

### hdl/json_string_unescape_utf16.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf16
// JSON string body unescaper: UTF-8 bytes in, UTF-16 code units out.
// ----------------------------------------------------------------------------
// One byte is taken per cycle, sustained, as long as the output side keeps
// up; each byte yields at most one code unit or status. A byte is classified
// on the cycle it is taken, waits in a QUEUE_DEPTH-entry queue, and the
// decoder's one-step state update turns it into a registered result, so a
// result passes the queue entry and then the output register. The decoder step
// per byte sets the rate. Escapes, \u with four hex digits and two- and
// three-byte UTF-8 give code units; a four-byte lead gives 0xFFFD and its
// next three bytes are skipped. The closing quote gives done, errors give
// their kind; after either, bytes are dropped until one marked first_byte.
module json_string_unescape_utf16 #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  in_byte,
    input  logic        first_byte,
    output logic        unit_valid,
    input  logic        unit_stall,
    output logic [15:0] code_unit,
    output logic [2:0]  kind
);
    import jsu_pkg::*;

    jsu_item_t front_item;
    jsu_item_t q_item;
    logic      push;
    logic      q_full;
    logic      q_valid;
    logic      pop;

    jsu_front u_front (
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .in_byte    (in_byte),
        .first_byte (first_byte),
        .q_full     (q_full),
        .push       (push),
        .item       (front_item)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_item  (front_item),
        .full     (q_full),
        .pop      (pop),
        .rd_valid (q_valid),
        .rd_item  (q_item)
    );

    jsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .pop        (pop),
        .unit_valid (unit_valid),
        .unit_stall (unit_stall),
        .code_unit  (code_unit),
        .kind       (kind)
    );

endmodule

### hdl/jsu_checker.sv
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks of the JSON string unescaper, bound to the top level.
// ----------------------------------------------------------------------------
module jsu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        byte_valid,
    input logic        byte_stall,
    input logic [7:0]  in_byte,
    input logic        first_byte,
    input logic        unit_valid,
    input logic        unit_stall,
    input logic [15:0] code_unit,
    input logic [2:0]  kind
);
    import jsu_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid && unit_stall |=> unit_valid && $stable(code_unit) && $stable(kind))
        else $error("stalled result changed");

    // status results carry no code unit
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid && kind != KIND_CHAR |-> code_unit == 16'h0000)
        else $error("status result with nonzero code unit");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid |-> kind != 3'd7)
        else $error("result kind out of range");

    // the queue only backs up behind a held result
    a_no_backup: assert property (@(posedge clk) disable iff (!rst_n)
        !unit_valid |-> !byte_stall)
        else $error("input stalled with no result waiting");

    // a stalled byte transfer holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_stall |=> byte_valid && $stable(in_byte) && $stable(first_byte))
        else $error("stalled byte changed");

endmodule

bind json_string_unescape_utf16 jsu_checker u_jsu_checker (.*);

### tb/json_string_unescape_utf16_test.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf16_test
// Self-checking bench for the JSON string unescaper. String bodies are fed as
// byte transfers under four pacing phases; every accepted byte is decoded
// by an in-bench model and each output transfer is checked in order.
// ----------------------------------------------------------------------------
module json_string_unescape_utf16_test;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_HEX    = 3'd2,
        MODE_CONT   = 3'd3,
        MODE_SKIP   = 3'd4
    } decode_mode_t;

    typedef struct packed {
        logic       first;
        logic [7:0] data;
    } raw_byte_t;

    typedef struct packed {
        logic [15:0] unit;
        logic [2:0]  kind;
    } decoded_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    logic [7:0]  in_byte = 8'h00;
    logic        first_byte = 1'b0;
    logic        unit_valid;
    logic        unit_stall = 1'b0;
    logic [15:0] code_unit;
    logic [2:0]  kind;

    raw_byte_t pending_bytes[$];
    decoded_t  expected_units[$];
    decoded_t  oldest_unit;
    raw_byte_t next_byte;

    // decoder state of the model
    decode_mode_t mode = MODE_NORMAL;
    logic [15:0]  partial = 16'h0;
    logic [1:0]   remaining = 2'd0;
    logic         str_open = 1'b0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int bytes_taken = 0;
    int results_seen = 0;
    int strings_sent = 0;
    int phase_items = 0;
    int kind_seen[8];
    bit first_next = 1'b0;

    logic [7:0] esc_chars[8] = '{8'h22, 8'h2F, 8'h5C, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74};
    logic [7:0] hex_chars[22] = '{"0", "1", "2", "3", "4", "5", "6", "7", "8", "9",
                                  "a", "b", "c", "d", "e", "f",
                                  "A", "B", "C", "D", "E", "F"};

    json_string_unescape_utf16 dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .in_byte    (in_byte),
        .first_byte (first_byte),
        .unit_valid (unit_valid),
        .unit_stall (unit_stall),
        .code_unit  (code_unit),
        .kind       (kind)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // decoder model
    // ------------------------------------------------------------------------
    function automatic void push_result(input logic [15:0] u, input logic [2:0] k);
        decoded_t r;
        r.unit = (k == KIND_CHAR) ? u : 16'h0;
        r.kind = k;
        expected_units.push_back(r);
        // done and errors close the string
        if (k != KIND_CHAR)
        begin
            str_open = 1'b0;
            mode = MODE_NORMAL;
            partial = 16'h0;
            remaining = 2'd0;
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic first);
        logic [7:0] esc;
        logic [3:0] digit;
        logic       is_digit;
        if (first)
        begin
            mode = MODE_NORMAL;
            partial = 16'h0;
            remaining = 2'd0;
            str_open = 1'b1;
        end
        if (!str_open)
            return;
        case (mode)
            MODE_ESC:
            begin
                if (b == CHAR_U)
                begin
                    partial = 16'h0;
                    remaining = 2'd3;
                    mode = MODE_HEX;
                end
                else
                begin
                    case (b)
                        8'h22:   esc = 8'h22;
                        8'h2F:   esc = 8'h2F;
                        8'h5C:   esc = 8'h5C;
                        8'h62:   esc = 8'h08;
                        8'h66:   esc = 8'h0C;
                        8'h6E:   esc = 8'h0A;
                        8'h72:   esc = 8'h0D;
                        8'h74:   esc = 8'h09;
                        default: esc = 8'h00;
                    endcase
                    if (esc == 8'h00)
                        push_result(16'h0, KIND_BAD_ESCAPE);
                    else
                    begin
                        mode = MODE_NORMAL;
                        push_result({8'h00, esc}, KIND_CHAR);
                    end
                end
            end
            MODE_HEX:
            begin
                is_digit = 1'b1;
                digit = 4'h0;
                if (b >= 8'h30 && b <= 8'h39)
                    digit = 4'(b - 8'h30);
                else if (b >= 8'h41 && b <= 8'h46)
                    digit = 4'(b - 8'h37);
                else if (b >= 8'h61 && b <= 8'h66)
                    digit = 4'(b - 8'h57);
                else
                    is_digit = 1'b0;
                if (!is_digit)
                    push_result(16'h0, KIND_BAD_HEX);
                else
                begin
                    partial = {partial[11:0], digit};
                    if (remaining == 2'd0)
                    begin
                        mode = MODE_NORMAL;
                        push_result(partial, KIND_CHAR);
                    end
                    else
                        remaining = remaining - 2'd1;
                end
            end
            MODE_CONT:
            begin
                if (b[7:6] != 2'b10)
                    push_result(16'h0, KIND_NO_CONT);
                else
                begin
                    partial = {partial[9:0], b[5:0]};
                    if (remaining <= 2'd1)
                    begin
                        remaining = 2'd0;
                        mode = MODE_NORMAL;
                        push_result(partial, KIND_CHAR);
                    end
                    else
                        remaining = remaining - 2'd1;
                end
            end
            MODE_SKIP:
            begin
                if (remaining <= 2'd1)
                begin
                    remaining = 2'd0;
                    mode = MODE_NORMAL;
                end
                else
                    remaining = remaining - 2'd1;
            end
            default:
            begin
                mode = MODE_NORMAL;
                if (b == CHAR_QUOTE)
                    push_result(16'h0, KIND_DONE);
                else if (b == CHAR_BSLASH)
                    mode = MODE_ESC;
                else if (b < 8'h80)
                    push_result({8'h00, b}, KIND_CHAR);
                else if (b[7:5] == 3'b110)
                begin
                    partial = {11'h0, b[4:0]};
                    remaining = 2'd1;
                    mode = MODE_CONT;
                end
                else if (b[7:4] == 4'b1110)
                begin
                    partial = {12'h0, b[3:0]};
                    remaining = 2'd2;
                    mode = MODE_CONT;
                end
                else if (b[7:3] == 5'b11110)
                begin
                    // replacement right away, next three bytes dropped unchecked
                    remaining = 2'd3;
                    mode = MODE_SKIP;
                    push_result(REPLACEMENT_UNIT, KIND_CHAR);
                end
                else if (b[7:2] == 6'b111110)
                    push_result(16'h0, KIND_TOO_LONG);
                else
                    push_result(16'h0, KIND_BAD_FIRST);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // byte sender, unit receiver and checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            in_byte <= 8'h00;
            first_byte <= 1'b0;
        end
        else if (!byte_valid || !byte_stall)
        begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_byte = pending_bytes.pop_front();
                byte_valid <= 1'b1;
                in_byte <= next_byte.data;
                first_byte <= next_byte.first;
            end
            else
                byte_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            unit_stall <= 1'b0;
        else
            unit_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && !byte_stall)
            begin
                bytes_taken++;
                decode_byte(in_byte, first_byte);
            end
            if (unit_valid && !unit_stall)
            begin
                results_seen++;
                kind_seen[kind]++;
                if (expected_units.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected transfer, got unit %h kind %0d",
                             $time, code_unit, kind);
                end
                else
                begin
                    oldest_unit = expected_units.pop_front();
                    if (code_unit !== oldest_unit.unit || kind !== oldest_unit.kind)
                    begin
                        errors++;
                        $display("%0t: mismatch, expected unit %h kind %0d, got unit %h kind %0d",
                                 $time, oldest_unit.unit, oldest_unit.kind, code_unit, kind);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic put(input logic [7:0] b);
        pending_bytes.push_back(raw_byte_t'{first: first_next, data: b});
        if (first_next)
            strings_sent++;
        first_next = 1'b0;
        phase_items++;
    endtask

    // a byte sent while no string is open, dropped by the block
    task automatic put_ignored(input logic [7:0] b);
        pending_bytes.push_back(raw_byte_t'{first: 1'b0, data: b});
    endtask

    task automatic directed_strings();
        first_next = 1'b1;
        put(8'h00); put(8'h7F);
        put(CHAR_BSLASH); put(CHAR_U); put("F"); put("f"); put("a"); put("9");
        put(8'hC3); put(8'hA9);
        put(8'hEF); put(8'hBF); put(8'hBF);
        // skipped tail holds a quote and a backslash
        put(8'hF0); put(CHAR_QUOTE); put(CHAR_BSLASH); put(8'hFF);
        put(CHAR_QUOTE);
        put_ignored("A");
        first_next = 1'b1; put(CHAR_BSLASH); put("x");
        first_next = 1'b1; put(CHAR_BSLASH); put(CHAR_U); put("0"); put(CHAR_QUOTE);
        first_next = 1'b1; put(8'hC2); put(CHAR_QUOTE);
        first_next = 1'b1; put(8'hF8);
        first_next = 1'b1; put(8'h80);
        first_next = 1'b1; put(8'hFE);
        first_next = 1'b1; put(8'hFF);
        // restart in the middle of a three-byte sequence
        first_next = 1'b1; put(8'hE2); put(8'h82);
        first_next = 1'b1; put("Z"); put(CHAR_QUOTE);
    endtask

    task automatic random_string();
        int n;
        int pick;
        logic [7:0] b;
        if ($urandom_range(99) < 5)
        begin
            // raw noise with random first marks
            n = $urandom_range(1, 8);
            repeat (n)
            begin
                first_next = 1'($urandom_range(1));
                put(8'($urandom_range(255)));
            end
            return;
        end
        first_next = 1'b1;
        n = $urandom_range(1, 12);
        repeat (n)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                do
                    b = 8'($urandom_range(127));
                while (b == CHAR_QUOTE || b == CHAR_BSLASH);
                put(b);
            end
            else if (pick < 50)
            begin
                put(CHAR_BSLASH);
                put(esc_chars[$urandom_range(7)]);
            end
            else if (pick < 60)
            begin
                put(CHAR_BSLASH);
                put(CHAR_U);
                repeat (4)
                    put(hex_chars[$urandom_range(21)]);
            end
            else if (pick < 72)
            begin
                put({3'b110, 5'($urandom_range(31))});
                put({2'b10, 6'($urandom_range(63))});
            end
            else if (pick < 84)
            begin
                put({4'b1110, 4'($urandom_range(15))});
                repeat (2)
                    put({2'b10, 6'($urandom_range(63))});
            end
            else if (pick < 90)
            begin
                put({5'b11110, 3'($urandom_range(7))});
                repeat (3)
                    put(8'($urandom_range(255)));
            end
            else
                put(8'($urandom_range(255)));
        end
        pick = $urandom_range(99);
        if (pick < 88)
        begin
            put(CHAR_QUOTE);
            if (pick < 10)
                repeat ($urandom_range(1, 3))
                    put_ignored(8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            if (ph == 0)
                directed_strings();
            phase_items = 0;
            while (phase_items < 400)
                random_string();
            while (pending_bytes.size() != 0 || byte_valid || expected_units.size() != 0)
                @(posedge clk);
        end
        repeat (16) @(posedge clk);
        if (expected_units.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected units never arrived", $time, expected_units.size());
        end
        $display("covered %0d strings, %0d byte transfers, %0d unit transfers in four pacings",
                 strings_sent, bytes_taken, results_seen);
        $display("kinds: char %0d done %0d esc %0d hex %0d cont %0d long %0d lead %0d",
                 kind_seen[KIND_CHAR], kind_seen[KIND_DONE], kind_seen[KIND_BAD_ESCAPE],
                 kind_seen[KIND_BAD_HEX], kind_seen[KIND_NO_CONT], kind_seen[KIND_TOO_LONG],
                 kind_seen[KIND_BAD_FIRST]);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### sim.f
hdl/jsu_pkg.sv
hdl/jsu_front.sv
hdl/jsu_queue.sv
hdl/jsu_back.sv
hdl/json_string_unescape_utf16.sv
hdl/jsu_checker.sv
tb/json_string_unescape_utf16_test.sv
